// ----- src/bba_pkg.sv -----
// Package: types, constants and helper functions of the buddy allocator.
package bba_pkg;

  localparam int MaxOrder  = 12;
  localparam int LvlW      = 4;
  localparam int OffW      = MaxOrder;
  localparam int SizeW     = MaxOrder + 1;
  localparam int NodeW     = MaxOrder + 1;
  localparam int WordW     = 32;
  localparam int BitW      = 5;
  localparam int RamAw     = NodeW - BitW;
  localparam int RamDepth  = 2 ** RamAw;
  localparam int FragW     = 12;
  localparam int PartW     = 12;
  // Highest level whose nodes fill whole memory words.
  localparam int FullLvl   = MaxOrder - BitW;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [SizeW-1:0] request_size;
    logic [OffW-1:0]  block_offset;
  } in_item_t;

  typedef struct packed {
    logic             granted;
    logic [OffW-1:0]  result_offset;
    logic [FragW-1:0] frag_bytes;
    logic [SizeW-1:0] free_bytes;
    logic [PartW-1:0] free_parts;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [RamAw-1:0] waddr;
    logic [WordW-1:0] wdata;
    logic [RamAw-1:0] raddr;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_S_RD,
    S_S_WR,
    S_F_RD,
    S_F_CHK,
    S_T_RD,
    S_T_CHK,
    S_DONE
  } state_e;

  // Bit address of the node for a block of level lvl at byte offset off.
  function automatic logic [NodeW-1:0] node_addr(input logic [LvlW-1:0] lvl,
                                                 input logic [OffW-1:0] off);
    logic [NodeW-1:0] base;
    logic [NodeW-1:0] idx;
    base = NodeW'(1) << (LvlW'(MaxOrder) - lvl);
    idx  = NodeW'(off >> lvl);
    return base + idx;
  endfunction

  // Last memory word that holds nodes of level lvl.
  function automatic logic [RamAw-1:0] last_word(input logic [LvlW-1:0] lvl);
    logic [NodeW:0] top;
    top = ((NodeW+1)'(2) << (LvlW'(MaxOrder) - lvl)) - (NodeW+1)'(1);
    return top[NodeW-1:BitW];
  endfunction

  // Bits of a word that belong to level lvl.
  function automatic logic [WordW-1:0] lvl_mask(input logic [LvlW-1:0] lvl);
    logic [BitW:0]    lo;
    logic [WordW-1:0] m;
    if (lvl <= LvlW'(FullLvl)) begin
      m = '1;
    end else begin
      lo = (BitW+1)'(1) << (LvlW'(MaxOrder) - lvl);
      m  = ((WordW'(1) << {lo, 1'b0}) - WordW'(1)) & ~((WordW'(1) << lo) - WordW'(1));
    end
    return m;
  endfunction

  // Smallest s with 2^s >= n.
  function automatic logic [LvlW-1:0] ceil_log2(input logic [SizeW-1:0] n);
    logic [LvlW-1:0] r;
    r = LvlW'(SizeW);
    for (int s = SizeW; s >= 0; s--) begin
      if (((SizeW+1)'(1) << s) >= (SizeW+1)'(n)) begin
        r = LvlW'(s);
      end
    end
    return r;
  endfunction

endpackage

// ----- src/bba_bitmap_ram.sv -----
// Word-wide free bitmap memory, one write and one registered read port.
module bba_bitmap_ram (
  input  logic                          clk_i,
  input  bba_pkg::ram_req_t             req_i,
  output logic [bba_pkg::WordW-1:0]     rdata_o
);
  import bba_pkg::*;

  logic [WordW-1:0] mem [RamDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// ----- src/bba_ffs.sv -----
// Lowest set bit finder over one bitmap word.
module bba_ffs (
  input  logic [bba_pkg::WordW-1:0] word_i,
  output logic                      any_o,
  output logic [bba_pkg::BitW-1:0]  idx_o
);
  import bba_pkg::*;

  always_comb begin
    idx_o = '0;
    for (int b = WordW - 1; b >= 0; b--) begin
      if (word_i[b]) begin
        idx_o = BitW'(b);
      end
    end
  end

  assign any_o = |word_i;

endmodule

// ----- src/buddy_block_allocator.sv -----
// Top level: buddy allocator sequencer, counters and result register.
// One item at a time: the bitmap memory port sets the pace. An allocate scans up to
//   260 words at heap_order 12; a free reads one buddy word per merge level.
// Reset and every heap_order write run a clearing pass over all 256 words of the bitmap
//   memory; no item is accepted during it.
// Reset: heap_order 12, whole heap one free block, counters restored.
module buddy_block_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bba_pkg::in_item_t           in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bba_pkg::out_item_t          out_o,
  input  logic                        cfg_we_i,
  input  logic [3:0]                  cfg_wdata_i
);
  import bba_pkg::*;

  state_e state_q, state_d;

  logic [LvlW-1:0]  hord_q, hord_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [LvlW-1:0]  need_q, need_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [SizeW-1:0] size_q, size_d;
  logic [RamAw-1:0] widx_q, widx_d;
  logic [RamAw-1:0] clr_q, clr_d;
  logic [FragW-1:0] frag_q, frag_d;
  logic [SizeW-1:0] fbytes_q, fbytes_d;
  logic [PartW-1:0] fparts_q, fparts_d;
  logic             grant_q, grant_d;
  logic [OffW-1:0]  roff_q, roff_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  ram_req_t         ram_req;
  logic [WordW-1:0] rdata;
  logic [WordW-1:0] masked;
  logic             hit;
  logic [BitW-1:0]  hit_idx;

  logic [LvlW-1:0]  in_need;
  logic [NodeW-1:0] in_heap;
  logic [NodeW-1:0] split_node, buddy_node, tgt_node, top_node, hit_node;
  logic [SizeW-1:0] need_bytes;
  logic [SizeW-1:0] lvl_bytes;
  logic [LvlW-1:0]  cfg_hord;
  logic             rd_bit;
  logic             done_load;

  bba_bitmap_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  bba_ffs u_ffs (
    .word_i (masked),
    .any_o  (hit),
    .idx_o  (hit_idx)
  );

  // Operand decode for the incoming item and the current step.
  assign in_need    = ceil_log2(in_i.request_size);
  assign in_heap    = NodeW'(1) << hord_q;
  assign need_bytes = SizeW'(1) << need_q;
  assign lvl_bytes  = SizeW'(1) << lvl_q;
  assign masked     = rdata & lvl_mask(lvl_q);
  assign hit_node   = {widx_q, hit_idx};
  assign split_node = node_addr(lvl_q, off_q + OffW'(NodeW'(1) << lvl_q));
  assign buddy_node = node_addr(lvl_q, off_q ^ OffW'(NodeW'(1) << lvl_q));
  assign tgt_node   = node_addr(lvl_q, off_q);
  assign top_node   = node_addr(hord_q, '0);
  assign cfg_hord   = (cfg_wdata_i > 4'(MaxOrder)) ? LvlW'(MaxOrder) : LvlW'(cfg_wdata_i);
  assign rd_bit     = rdata[tgt_node[BitW-1:0]];
  assign done_load  = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == RamAw'(RamDepth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_need > hord_q) begin
            state_d = S_DONE;
          end else if (in_i.kind == KindAlloc) begin
            state_d = S_A_RD;
          end else if (NodeW'(in_i.block_offset) >= in_heap) begin
            state_d = S_DONE;
          end else if (in_need < hord_q) begin
            state_d = S_F_RD;
          end else begin
            state_d = S_T_RD;
          end
        end
      end
      S_A_RD:  state_d = S_A_CHK;
      S_A_CHK: begin
        if (hit) begin
          state_d = (lvl_q > need_q) ? S_S_RD : S_DONE;
        end else if (widx_q == last_word(lvl_q) && lvl_q == hord_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_A_RD;
        end
      end
      S_S_RD:  state_d = S_S_WR;
      S_S_WR:  state_d = (lvl_q > need_q) ? S_S_RD : S_DONE;
      S_F_RD:  state_d = S_F_CHK;
      S_F_CHK: begin
        if (rdata[buddy_node[BitW-1:0]] && (lvl_q + LvlW'(1) < hord_q)) begin
          state_d = S_F_RD;
        end else begin
          state_d = S_T_RD;
        end
      end
      S_T_RD:  state_d = S_T_CHK;
      S_T_CHK: state_d = S_DONE;
      S_DONE:  begin
        if (done_load) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
    if (cfg_we_i) state_d = S_CLEAR;
  end

  // Datapath, memory requests and result.
  always_comb begin
    hord_d      = hord_q;
    lvl_d       = lvl_q;
    need_d      = need_q;
    off_d       = off_q;
    size_d      = size_q;
    widx_d      = widx_q;
    clr_d       = clr_q;
    frag_d      = frag_q;
    fbytes_d    = fbytes_q;
    fparts_d    = fparts_q;
    grant_d     = grant_q;
    roff_d      = roff_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_req     = '0;
    in_ready_o  = (state_q == S_IDLE);

    unique case (state_q)
      S_CLEAR: begin
        // Sweep the bitmap, planting the whole-heap block on the way.
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
        ram_req.wdata = (clr_q == top_node[NodeW-1:BitW])
                        ? (WordW'(1) << top_node[BitW-1:0]) : '0;
        clr_d         = clr_q + RamAw'(1);
      end
      S_IDLE: begin
        need_d  = in_need;
        size_d  = in_i.request_size;
        lvl_d   = in_need;
        grant_d = 1'b0;
        roff_d  = '0;
        widx_d  = RamAw'(node_addr(in_need, '0) >> BitW);
        off_d   = in_i.block_offset & ~OffW'((NodeW'(1) << in_need) - NodeW'(1));
        if (in_valid_i && in_need <= hord_q && in_i.kind == KindFree
            && NodeW'(in_i.block_offset) < in_heap) begin
          frag_d = frag_q - FragW'((NodeW'(1) << in_need) - NodeW'(in_i.request_size));
        end
      end
      S_A_RD: begin
        ram_req.raddr = widx_q;
      end
      S_A_CHK: begin
        if (hit) begin
          // Take the block, then split down toward the needed level.
          ram_req.we    = 1'b1;
          ram_req.waddr = widx_q;
          ram_req.wdata = rdata & ~(WordW'(1) << hit_idx);
          fparts_d      = fparts_q - PartW'(1);
          off_d         = OffW'((hit_node - node_addr(lvl_q, '0)) << lvl_q);
          if (lvl_q > need_q) begin
            lvl_d = lvl_q - LvlW'(1);
          end else begin
            fbytes_d = fbytes_q - need_bytes;
            frag_d   = frag_q + FragW'(need_bytes - size_q);
            grant_d  = 1'b1;
            roff_d   = OffW'((hit_node - node_addr(lvl_q, '0)) << lvl_q);
          end
        end else if (widx_q == last_word(lvl_q)) begin
          lvl_d  = lvl_q + LvlW'(1);
          widx_d = RamAw'(node_addr(lvl_q + LvlW'(1), '0) >> BitW);
        end else begin
          widx_d = widx_q + RamAw'(1);
        end
      end
      S_S_RD: begin
        ram_req.raddr = split_node[NodeW-1:BitW];
      end
      S_S_WR: begin
        // Free the upper half at this level.
        ram_req.we    = 1'b1;
        ram_req.waddr = split_node[NodeW-1:BitW];
        ram_req.wdata = rdata | (WordW'(1) << split_node[BitW-1:0]);
        fparts_d      = fparts_q + PartW'(1);
        if (lvl_q > need_q) begin
          lvl_d = lvl_q - LvlW'(1);
        end else begin
          fbytes_d = fbytes_q - need_bytes;
          frag_d   = frag_q + FragW'(need_bytes - size_q);
          grant_d  = 1'b1;
          roff_d   = off_q;
        end
      end
      S_F_RD: begin
        ram_req.raddr = buddy_node[NodeW-1:BitW];
      end
      S_F_CHK: begin
        if (rdata[buddy_node[BitW-1:0]]) begin
          // Buddy free: absorb it and climb one level.
          ram_req.we    = 1'b1;
          ram_req.waddr = buddy_node[NodeW-1:BitW];
          ram_req.wdata = rdata & ~(WordW'(1) << buddy_node[BitW-1:0]);
          fparts_d      = fparts_q - PartW'(1);
          fbytes_d      = fbytes_q - lvl_bytes;
          off_d         = off_q & ~OffW'((NodeW'(2) << lvl_q) - NodeW'(1));
          lvl_d         = lvl_q + LvlW'(1);
        end
      end
      S_T_RD: begin
        ram_req.raddr = tgt_node[NodeW-1:BitW];
      end
      S_T_CHK: begin
        if (!rd_bit) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = tgt_node[NodeW-1:BitW];
          ram_req.wdata = rdata | (WordW'(1) << tgt_node[BitW-1:0]);
          fparts_d      = fparts_q + PartW'(1);
          fbytes_d      = fbytes_q + lvl_bytes;
        end
        grant_d = 1'b1;
      end
      S_DONE: begin
        if (done_load) begin
          out_valid_d         = 1'b1;
          out_d.granted       = grant_q;
          out_d.result_offset = roff_q;
          out_d.frag_bytes    = frag_q;
          out_d.free_bytes    = fbytes_q;
          out_d.free_parts    = fparts_q;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase

    // Re-initialize the heap on a register write.
    if (cfg_we_i) begin
      hord_d   = cfg_hord;
      clr_d    = '0;
      frag_d   = '0;
      fbytes_d = SizeW'(1) << cfg_hord;
      fparts_d = PartW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      hord_q      <= LvlW'(MaxOrder);
      clr_q       <= '0;
      frag_q      <= '0;
      fbytes_q    <= SizeW'(1) << MaxOrder;
      fparts_q    <= PartW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hord_q      <= hord_d;
      clr_q       <= clr_d;
      frag_q      <= frag_d;
      fbytes_q    <= fbytes_d;
      fparts_q    <= fparts_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    need_q  <= need_d;
    off_q   <= off_d;
    size_q  <= size_d;
    widx_q  <= widx_d;
    grant_q <= grant_d;
    roff_q  <= roff_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- bench/buddy_block_allocator_tb.sv -----
// Testbench for the buddy block allocator: random and directed items against a bitmap predictor.
`timescale 1ns / 100ps

module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int MapSize = (2 << MaxOrder) - 1;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_item_t   in_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_o;
  logic       cfg_we_i = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;

  buddy_block_allocator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state: one free bit per block per level, plus the running counters.
  bit          free_bits [MapSize];
  int unsigned heap_lvl;
  int unsigned frag_sum;
  int unsigned free_sum;
  int unsigned free_cnt;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        fail_count = 0;
  bit        quiet_in = 1'b0;   // no idling on the input side
  bit        quiet_out = 1'b0;  // no stalls on the output side
  bit        hold_out = 1'b0;   // long receiver hold-off

  function automatic int unsigned node_of(int unsigned lvl, int unsigned off);
    int unsigned idx;
    idx = ((1 << (MaxOrder - lvl)) - 1) + (off >> lvl);
    return (idx < MapSize) ? idx : 0;
  endfunction

  function automatic int unsigned size_level(int unsigned n);
    int unsigned s;
    s = 0;
    while (s < 31 && (1 << s) < n) s++;
    return s;
  endfunction

  // Re-initialize the heap for a new order.
  task automatic heap_init(input int unsigned order);
    heap_lvl = (order > MaxOrder) ? MaxOrder : order;
    foreach (free_bits[i]) free_bits[i] = 1'b0;
    free_bits[node_of(heap_lvl, 0)] = 1'b1;
    frag_sum = 0;
    free_sum = 1 << heap_lvl;
    free_cnt = 1;
  endtask

  // Apply one item to the predictor and return what the block should report.
  function automatic out_item_t buddy_predict(in_item_t it);
    out_item_t   r;
    int unsigned need, heap, lvl, o, sz;
    bit          found;
    r = '0;
    sz = it.request_size;
    need = size_level(sz);
    heap = 1 << heap_lvl;
    if (need <= heap_lvl) begin
      if (it.kind == KindAlloc) begin
        found = 1'b0;
        o = 0;
        lvl = need;
        while (lvl <= heap_lvl && !found) begin
          for (o = 0; o < heap; o += (1 << lvl))
            if (free_bits[node_of(lvl, o)]) begin
              found = 1'b1;
              break;
            end
          if (!found) lvl++;
        end
        if (found) begin
          free_bits[node_of(lvl, o)] = 1'b0;
          free_cnt--;
          while (lvl > need) begin
            lvl--;
            free_bits[node_of(lvl, o + (1 << lvl))] = 1'b1;
            free_cnt++;
          end
          free_sum -= 1 << need;
          frag_sum = (frag_sum + (1 << need) - sz) & 12'hFFF;
          r.granted = 1'b1;
          r.result_offset = o[OffW-1:0];
        end
      end else if (it.block_offset < heap) begin
        lvl = need;
        o = it.block_offset & (32'hFFFF_FFFF << lvl);
        frag_sum = (frag_sum - ((1 << need) - sz)) & 12'hFFF;
        while (lvl < heap_lvl) begin
          if (!free_bits[node_of(lvl, o ^ (1 << lvl))]) break;
          free_bits[node_of(lvl, o ^ (1 << lvl))] = 1'b0;
          free_cnt--;
          free_sum -= 1 << lvl;
          o &= 32'hFFFF_FFFF << (lvl + 1);
          lvl++;
        end
        if (!free_bits[node_of(lvl, o)]) begin
          free_bits[node_of(lvl, o)] = 1'b1;
          free_cnt++;
          free_sum += 1 << lvl;
        end
        r.granted = 1'b1;
      end
    end
    r.frag_bytes = frag_sum[FragW-1:0];
    r.free_bytes = free_sum[SizeW-1:0];
    r.free_parts = free_cnt[PartW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got, exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    fail_count++;
  endtask

  // Driver: present the next item, hold it until accepted, idle at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(buddy_predict(in_i));
        void'(pending_items.pop_front());
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (pending_items.size() > 0 &&
            (quiet_in || $urandom_range(99) >= 12)) begin
          in_valid_i <= 1'b1;
          in_i <= pending_items[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_o.granted !== e.granted)
            report_mismatch("granted", out_o.granted, e.granted);
          if (out_o.result_offset !== e.result_offset)
            report_mismatch("result_offset", out_o.result_offset, e.result_offset);
          if (out_o.frag_bytes !== e.frag_bytes)
            report_mismatch("frag_bytes", out_o.frag_bytes, e.frag_bytes);
          if (out_o.free_bytes !== e.free_bytes)
            report_mismatch("free_bytes", out_o.free_bytes, e.free_bytes);
          if (out_o.free_parts !== e.free_parts)
            report_mismatch("free_parts", out_o.free_parts, e.free_parts);
        end
      end
      out_ready_i <= !hold_out && (quiet_out || $urandom_range(99) >= 12);
    end
  end

  function automatic in_item_t make_item(bit k, int unsigned sz, int unsigned off);
    in_item_t it;
    it.kind = k;
    it.request_size = sz[SizeW-1:0];
    it.block_offset = off[OffW-1:0];
    return it;
  endfunction

  // Wait until every queued item has been accepted and answered, then let the block settle.
  task automatic drain;
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_order(input int unsigned order);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= order[3:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    heap_init(order);
  endtask

  // Random phase: allocates and frees at random sizes and aligned offsets, some noise.
  // No allocated blocks are tracked (the queue runs ahead); the predictor is what checks.
  task automatic random_phase(input int n);
    int unsigned sz, off, pick, max_sz;
    for (int i = 0; i < n; i++) begin
      max_sz = 1 << heap_lvl;
      pick = $urandom_range(99);
      if (pick < 50) begin
        sz = (pick < 5) ? $urandom_range(8191) : $urandom_range(max_sz < 64 ? max_sz : 64);
        if (pick == 6) sz = max_sz;
        pending_items.push_back(make_item(KindAlloc, sz, $urandom));
        // remember a guess of the offset using a shadow predictor is not possible here,
        // so frees pick sizes and aligned offsets at random within the heap
      end else if (pick < 92) begin
        sz = $urandom_range(max_sz < 64 ? max_sz : 64);
        off = $urandom_range(max_sz - 1) & (32'hFFFF_FFFF << size_level(sz));
        pending_items.push_back(make_item(KindFree, sz, off));
      end else begin
        pending_items.push_back(make_item($urandom_range(1), $urandom_range(8191),
                                          $urandom_range(4095)));
      end
    end
  endtask

  initial begin
    heap_init(12);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, zero size, too large, no block, outside heap, unaligned free.
    pending_items.push_back(make_item(KindAlloc, 0, 0));
    pending_items.push_back(make_item(KindAlloc, 4096, 0));
    pending_items.push_back(make_item(KindAlloc, 8191, 4095));
    pending_items.push_back(make_item(KindAlloc, 3, 0));
    pending_items.push_back(make_item(KindAlloc, 2048, 0));
    pending_items.push_back(make_item(KindFree, 0, 0));
    pending_items.push_back(make_item(KindFree, 3, 4095));
    pending_items.push_back(make_item(KindFree, 8191, 0));
    pending_items.push_back(make_item(KindFree, 2048, 2049));
    pending_items.push_back(make_item(KindFree, 4, 4));
    pending_items.push_back(make_item(KindFree, 4096, 0));
    pending_items.push_back(make_item(KindAlloc, 4096, 0));
    pending_items.push_back(make_item(KindAlloc, 1, 0));
    pending_items.push_back(make_item(KindFree, 4096, 0));
    drain();

    write_order(0);
    pending_items.push_back(make_item(KindAlloc, 1, 0));
    pending_items.push_back(make_item(KindAlloc, 1, 0));
    pending_items.push_back(make_item(KindFree, 1, 1));
    pending_items.push_back(make_item(KindFree, 2, 0));
    pending_items.push_back(make_item(KindFree, 1, 0));
    random_phase(40);
    drain();

    write_order(15);  // capped at the top order
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    random_phase(300);
    drain();
    quiet_in = 1'b0;
    quiet_out = 1'b0;

    write_order(5);
    random_phase(400);
    // Hold the receiver off while the sender keeps offering items.
    hold_out = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_out = 1'b0;
    drain();

    write_order(8);
    random_phase(500);
    drain();

    write_order(12);
    random_phase(680);
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
